// ----- hdl/dfl_pkg.sv -----
// Shared types, constants and the exponent table for the box decoder.
// No dependencies; every other file in the block imports this package.
package dfl_pkg;

  localparam int BINS_DEF        = 16;
  localparam int MAX_CLASSES_DEF = 256;
  localparam int QUOT_W          = 17;
  localparam logic [16:0] LOG2E_Q16 = 17'd94548;

  localparam logic [1:0] REG_THRESHOLD   = 2'd0;
  localparam logic [1:0] REG_STRIDE      = 2'd1;
  localparam logic [1:0] REG_CLASS_COUNT = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE, S_MAX, S_EXP, S_DRAIN, S_DDIV0, S_DRUN, S_EDGE,
    S_SEXP, S_SDRAIN, S_SDIV0, S_SRUN, S_SOUT
  } dfl_state_t;

  typedef struct packed {
    logic accept;
    logic max_step;
    logic exp_bin;
    logic exp_cls;
    logic div_start;
    logic div_cls;
    logic edge_wr;
    logic out_load;
  } dfl_cmd_t;

  typedef struct packed {
    logic go_close;
    logic go_class;
    logic k_last;
    logic exp_busy;
    logic div_done;
    logic out_free;
  } dfl_stat_t;

  // 2^(-j/16) in Q.16 for j = 0..16.
  function automatic logic [16:0] pow2_frac(input logic [4:0] j);
    logic [16:0] v;
    case (j)
      5'd0:  v = 17'd65536;
      5'd1:  v = 17'd62757;
      5'd2:  v = 17'd60097;
      5'd3:  v = 17'd57549;
      5'd4:  v = 17'd55109;
      5'd5:  v = 17'd52773;
      5'd6:  v = 17'd50535;
      5'd7:  v = 17'd48393;
      5'd8:  v = 17'd46341;
      5'd9:  v = 17'd44376;
      5'd10: v = 17'd42495;
      5'd11: v = 17'd40693;
      5'd12: v = 17'd38968;
      5'd13: v = 17'd37316;
      5'd14: v = 17'd35734;
      5'd15: v = 17'd34219;
      default: v = 17'd32768;
    endcase
    return v;
  endfunction

endpackage

// ----- hdl/dfl_exp.sv -----
// Two-stage exp(-d) unit: log2(e) scaling, then table interpolation and shift.
// Depends on dfl_pkg for the constant and the table.
module dfl_exp (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic [15:0] d,
  output logic        out_valid,
  output logic [16:0] w,
  output logic        busy
);
  import dfl_pkg::*;

  logic        v1;
  logic [16:0] t1;
  logic [32:0] prod;
  logic [8:0]  ti;
  logic [3:0]  hi;
  logic [3:0]  lo;
  logic [16:0] ta;
  logic [16:0] tb;
  logic [15:0] diff;
  logic [15:0] dl;
  logic [16:0] m;

  assign prod = 33'(d) * 33'(LOG2E_Q16);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v1 <= in_valid;
      out_valid <= v1;
    end
    t1 <= prod[32:16];
    w <= (ti >= 9'd17) ? 17'd0 : (m >> ti[4:0]);
  end

  always_comb begin
    ti = t1[16:8];
    hi = t1[7:4];
    lo = t1[3:0];
    ta = pow2_frac({1'b0, hi});
    tb = pow2_frac({1'b0, hi} + 5'd1);
    diff = 16'(ta - tb);
    dl = diff * {12'd0, lo};
    m = ta - {5'd0, dl[15:4]};
  end

  assign busy = v1 | out_valid;

endmodule

// ----- hdl/dfl_div.sv -----
// Restoring divider, one quotient bit per cycle, for distances and sigmoid.
// Depends on dfl_pkg for the quotient width.
module dfl_div #(
  parameter int NUM_W = 34,
  parameter int DEN_W = 18
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [NUM_W-1:0]         num,
  input  logic [DEN_W-1:0]         den,
  output logic [dfl_pkg::QUOT_W-1:0] q,
  output logic                     done
);
  import dfl_pkg::*;

  localparam int W = (NUM_W > DEN_W + QUOT_W) ? NUM_W : DEN_W + QUOT_W;
  localparam int CNT_W = $clog2(QUOT_W);

  logic [W-1:0]     rem;
  logic [W-1:0]     dsh;
  logic [CNT_W-1:0] cnt;
  logic             run;

  always_ff @(posedge clk) begin
    if (rst) begin
      run <= 1'b0;
      done <= 1'b0;
    end else if (start) begin
      run <= 1'b1;
      done <= 1'b0;
    end else if (run && cnt == '0) begin
      run <= 1'b0;
      done <= 1'b1;
    end
    if (start) begin
      rem <= W'(num);
      dsh <= W'(den) << (QUOT_W - 1);
      cnt <= CNT_W'(QUOT_W - 1);
    end else if (run) begin
      if (rem >= dsh) begin
        rem <= rem - dsh;
        q <= {q[QUOT_W-2:0], 1'b1};
      end else begin
        q <= {q[QUOT_W-2:0], 1'b0};
      end
      dsh <= dsh >> 1;
      cnt <= cnt - 1'b1;
    end
  end

endmodule

// ----- hdl/dfl_dp.sv -----
// Datapath: config registers, bin store, max and weighted sums, edges, output word.
// Depends on dfl_pkg, dfl_exp and dfl_div.
module dfl_dp #(
  parameter int BINS        = dfl_pkg::BINS_DEF,
  parameter int MAX_CLASSES = dfl_pkg::MAX_CLASSES_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [15:0]         cfg_data,
  input  logic [31:0]         s_tdata,
  input  logic                s_tuser,
  input  dfl_pkg::dfl_cmd_t   cmd,
  output dfl_pkg::dfl_stat_t  stat,
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [103:0]        m_tdata
);
  import dfl_pkg::*;

  localparam int BIN_W = $clog2(BINS);
  localparam int SUM_W = 17 + BIN_W;
  localparam int ACC_W = 17 + 2 * BIN_W;
  localparam int NUM_W = (ACC_W + 9 > 34) ? ACC_W + 9 : 34;
  localparam int DEN_W = (SUM_W > 18) ? SUM_W : 18;
  localparam int CC_W  = $clog2(MAX_CLASSES + 1);

  logic signed [15:0] threshold;
  logic [2:0]         stride;
  logic [8:0]         class_count;

  logic signed [15:0] bin_store [BINS];
  logic [BIN_W-1:0]   pos;
  logic [1:0]         side;
  logic [CC_W-1:0]    cc;

  logic signed [15:0] it_logit;
  logic [7:0]         it_cx;
  logic [7:0]         it_cy;
  logic [1:0]         it_side;
  logic               it_cls;
  logic [7:0]         label_r;

  logic [BIN_W-1:0]   k;
  logic [BIN_W-1:0]   k1;
  logic [BIN_W-1:0]   k2;
  logic signed [15:0] mx;
  logic [SUM_W-1:0]   sum;
  logic [ACC_W-1:0]   acc;
  logic [16:0]        e_cls;

  logic signed [19:0] box [4];
  logic [7:0]         out_label;
  logic [15:0]        out_conf;
  logic signed [19:0] out_box [4];

  logic signed [15:0] in_logit;
  logic               cls_ok;
  logic               k_last;
  logic               exp_in_v;
  logic [15:0]        exp_d;
  logic [16:0]        mdiff;
  logic               w_v;
  logic [16:0]        w;
  logic               exp_busy;
  logic [NUM_W-1:0]   div_num;
  logic [DEN_W-1:0]   div_den;
  logic [17:0]        sden;
  logic [QUOT_W-1:0]  q;
  logic               div_done;
  logic [11:0]        side_dist;
  logic [15:0]        cpos;
  logic signed [17:0] edge_e;
  logic signed [25:0] edge_s;
  logic signed [21:0] edge_r;
  logic signed [19:0] edge_q;
  logic               out_free;

  assign in_logit = $signed(s_tdata[15:0]);
  assign cls_ok = (10'(cc) < 10'(class_count)) && (10'(cc) < 10'(MAX_CLASSES));
  assign k_last = (k == BIN_W'(BINS - 1));
  assign out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= 16'sd0;
      stride <= 3'd3;
      class_count <= 9'd80;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_THRESHOLD:   threshold <= $signed(cfg_data);
        REG_STRIDE:      stride <= cfg_data[2:0];
        REG_CLASS_COUNT: class_count <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
      side <= 2'd0;
      cc <= '0;
    end else if (cmd.accept) begin
      if (!s_tuser) begin
        cc <= '0;
        if (pos == BIN_W'(BINS - 1)) begin
          pos <= '0;
          side <= side + 2'd1;
        end else begin
          pos <= pos + 1'b1;
        end
      end else if (cls_ok) begin
        cc <= CC_W'(cc + 1'b1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      if (!s_tuser) begin
        bin_store[pos] <= in_logit;
      end
      it_logit <= in_logit;
      it_cx <= s_tdata[23:16];
      it_cy <= s_tdata[31:24];
      it_side <= side;
      it_cls <= s_tuser;
      label_r <= 8'(cc);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      k <= '0;
      mx <= -16'sd32768;
      sum <= '0;
      acc <= '0;
    end else begin
      if (cmd.max_step) begin
        if (bin_store[k] > mx) begin
          mx <= bin_store[k];
        end
      end
      if (cmd.max_step || cmd.exp_bin) begin
        k <= k_last ? '0 : k + 1'b1;
      end
      if (w_v && !it_cls) begin
        sum <= sum + SUM_W'(w);
        acc <= acc + ACC_W'(w) * ACC_W'(k2);
      end
    end
    k1 <= k;
    k2 <= k1;
    if (w_v && it_cls) begin
      e_cls <= w;
    end
  end

  always_comb begin
    mdiff = 17'(mx) - 17'(bin_store[k]);
    exp_in_v = cmd.exp_bin || cmd.exp_cls;
    if (cmd.exp_cls) begin
      exp_d = it_logit[15] ? 16'(-it_logit) : it_logit;
    end else begin
      exp_d = mdiff[15:0];
    end
  end

  dfl_exp u_exp (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (exp_in_v),
    .d         (exp_d),
    .out_valid (w_v),
    .w         (w),
    .busy      (exp_busy)
  );

  always_comb begin
    sden = 18'd65536 + 18'(e_cls);
    if (cmd.div_cls) begin
      div_den = DEN_W'(sden);
      if (!it_logit[15]) begin
        div_num = (NUM_W'(1) << 32) + NUM_W'(sden >> 1);
      end else begin
        div_num = (NUM_W'(e_cls) << 16) + NUM_W'(sden >> 1);
      end
    end else begin
      div_den = DEN_W'(sum);
      div_num = (NUM_W'(acc) << 8) + NUM_W'(sum >> 1);
    end
  end

  dfl_div #(.NUM_W(NUM_W), .DEN_W(DEN_W)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .num   (div_num),
    .den   (div_den),
    .q     (q),
    .done  (div_done)
  );

  always_comb begin
    side_dist = (q > QUOT_W'(4095)) ? 12'd4095 : q[11:0];
    cpos = {(it_side[0] ? it_cy : it_cx), 8'h80};
    if (it_side[1]) begin
      edge_e = $signed({2'b00, cpos}) + $signed({6'd0, side_dist});
    end else begin
      edge_e = $signed({2'b00, cpos}) - $signed({6'd0, side_dist});
    end
    edge_s = (26'(edge_e) <<< stride) + 26'sd8;
    edge_r = 22'(edge_s >>> 4);
    if (edge_r > 22'sd524287) begin
      edge_q = 20'sd524287;
    end else if (edge_r < -22'sd524288) begin
      edge_q = -20'sd524288;
    end else begin
      edge_q = 20'(edge_r);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 4; i++) begin
        box[i] <= 20'sd0;
      end
    end else if (cmd.edge_wr) begin
      box[it_side] <= edge_q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
    if (cmd.out_load) begin
      out_label <= label_r;
      out_conf <= (q > QUOT_W'(65535)) ? 16'hFFFF : q[15:0];
      for (int i = 0; i < 4; i++) begin
        out_box[i] <= box[i];
      end
    end
  end

  assign m_tdata = {out_box[3], out_box[2], out_box[1], out_box[0], out_conf, out_label};

  always_comb begin
    stat.go_close = !s_tuser && (pos == BIN_W'(BINS - 1));
    stat.go_class = s_tuser && cls_ok && (in_logit > threshold);
    stat.k_last = k_last;
    stat.exp_busy = exp_busy;
    stat.div_done = div_done;
    stat.out_free = out_free;
  end

endmodule

// ----- hdl/dfl_ctrl.sv -----
// Controller state machine sequencing the datapath through each item.
// Depends on dfl_pkg for the state, command and status types.
module dfl_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  dfl_pkg::dfl_stat_t stat,
  output dfl_pkg::dfl_cmd_t  cmd
);
  import dfl_pkg::*;

  dfl_state_t state;
  dfl_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (s_tvalid && stat.go_close) begin
          state_next = S_MAX;
        end else if (s_tvalid && stat.go_class) begin
          state_next = S_SEXP;
        end
      end
      S_MAX:    if (stat.k_last) state_next = S_EXP;
      S_EXP:    if (stat.k_last) state_next = S_DRAIN;
      S_DRAIN:  if (!stat.exp_busy) state_next = S_DDIV0;
      S_DDIV0:  state_next = S_DRUN;
      S_DRUN:   if (stat.div_done) state_next = S_EDGE;
      S_EDGE:   state_next = S_IDLE;
      S_SEXP:   state_next = S_SDRAIN;
      S_SDRAIN: if (!stat.exp_busy) state_next = S_SDIV0;
      S_SDIV0:  state_next = S_SRUN;
      S_SRUN:   if (stat.div_done) state_next = S_SOUT;
      S_SOUT:   if (stat.out_free) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_comb begin
    s_tready = (state == S_IDLE);
    cmd.accept = (state == S_IDLE) && s_tvalid;
    cmd.max_step = (state == S_MAX);
    cmd.exp_bin = (state == S_EXP);
    cmd.exp_cls = (state == S_SEXP);
    cmd.div_start = (state == S_DDIV0) || (state == S_SDIV0);
    cmd.div_cls = (state == S_SDIV0);
    cmd.edge_wr = (state == S_EDGE);
    cmd.out_load = (state == S_SOUT) && stat.out_free;
  end

endmodule

// ----- hdl/dfl_box_decode_conf_filter.sv -----
// Box decode and confidence filter: a bin or non-passing class word is taken without leaving idle.
// A side's closing bin runs a max pass, an exp pass, a drain and the divider, then writes its edge.
// A passing class word goes through the exp unit and the 17-step divider to its result.
// Results wait in an output register; input is not blocked by it until the next pass.
// Synchronous active-high reset clears control state, counters and box edges, and restores config defaults.
module dfl_box_decode_conf_filter #(
  parameter int BINS        = dfl_pkg::BINS_DEF,
  parameter int MAX_CLASSES = dfl_pkg::MAX_CLASSES_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [15:0]  cfg_data,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [31:0]  s_tdata,   // logit, cell_x, cell_y
  input  logic         s_tuser,   // cmd
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [103:0] m_tdata    // label, confidence, x_min, y_min, x_max, y_max
);
  import dfl_pkg::*;

  dfl_cmd_t  cmd;
  dfl_stat_t stat;

  dfl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  dfl_dp #(.BINS(BINS), .MAX_CLASSES(MAX_CLASSES)) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .cmd       (cmd),
    .stat      (stat),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

endmodule

// ----- test/tb_top.sv -----
// Self-checking testbench for the box decoder with confidence filter.
// It drives bin and class words and compares every result word with its own prediction.
// It depends only on dfl_pkg and dfl_box_decode_conf_filter.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import dfl_pkg::*;

  localparam int LIMIT = 1000000;
  localparam int DRAIN_CYCLES = 120;
  localparam int HOLD_CYCLES = 3000;

  typedef struct {
    logic [7:0] label;
    logic [15:0] confidence;
    logic signed [19:0] edge_q4 [4];
  } detection_t;

  class detection_board;
    int errors;
    logic signed [15:0] threshold;
    int unsigned stride;
    int unsigned class_count;
    int bin_logits [16];
    int unsigned bin_pos;
    int unsigned class_pos;
    int signed edges [4];
    detection_t pending [$];
    int unsigned exp_tab [17] = '{65536, 62757, 60097, 57549, 55109, 52773, 50535,
      48393, 46341, 44376, 42495, 40693, 38968, 37316, 35734, 34219, 32768};

    function new();
      errors = 0;
      threshold = 0;
      stride = 3;
      class_count = 80;
      bin_pos = 0;
      class_pos = 0;
      foreach (bin_logits[k]) bin_logits[k] = 0;
      foreach (edges[k]) edges[k] = 0;
    endfunction

    function void write_reg(logic [1:0] index, logic [15:0] value);
      if (index == REG_THRESHOLD) threshold = value;
      else if (index == REG_STRIDE) stride = value[2:0];
      else if (index == REG_CLASS_COUNT) class_count = value[8:0];
    endfunction

    function longint unsigned exp_neg(longint unsigned d);
      longint unsigned t, ti, frac_hi, frac_lo, m;
      t = (d * 94548) >> 16;
      ti = t >> 8;
      frac_hi = (t & 255) >> 4;
      frac_lo = t & 15;
      m = exp_tab[frac_hi] - (((exp_tab[frac_hi] - exp_tab[frac_hi + 1]) * frac_lo) >> 4);
      if (ti >= 17) return 0;
      return m >> ti;
    endfunction

    function logic [15:0] sigmoid(int x);
      longint unsigned e, den, num, r;
      e = exp_neg(x >= 0 ? x : -x);
      den = 65536 + e;
      num = (x >= 0) ? (64'd1 << 32) : 65536 * e;
      r = (num + den / 2) / den;
      return (r > 65535) ? 16'hFFFF : r[15:0];
    endfunction

    function int edge_from_q8(longint e_q8);
      longint v;
      v = (e_q8 * (longint'(1) << stride) + 8) >>> 4;
      if (v > 524287) v = 524287;
      if (v < -524288) v = -524288;
      return int'(v);
    endfunction

    function void close_side(int unsigned side, int unsigned cx, int unsigned cy);
      int mx;
      longint unsigned w, total, acc, q, side_dist;
      longint c;
      mx = bin_logits[0];
      total = 0;
      acc = 0;
      for (int k = 1; k < 16; k++) if (bin_logits[k] > mx) mx = bin_logits[k];
      for (int k = 0; k < 16; k++) begin
        w = exp_neg(mx - bin_logits[k]);
        total += w;
        acc += w * k;
      end
      q = (acc * 256 + total / 2) / total;
      side_dist = (q > 4095) ? 4095 : q;
      c = ((side & 1) ? cy : cx) * 256 + 128;
      edges[side] = edge_from_q8(side < 2 ? c - longint'(side_dist)
                                          : c + longint'(side_dist));
    endfunction

    function void note_input(logic cmd, logic signed [15:0] logit, logic [7:0] cx,
                             logic [7:0] cy);
      int unsigned limit;
      detection_t d;
      if (cmd == 1'b0) begin
        bin_logits[bin_pos % 16] = logit;
        class_pos = 0;
        if (bin_pos % 16 == 15) close_side((bin_pos / 16) & 3, cx, cy);
        bin_pos = (bin_pos + 1) % 64;
      end else begin
        limit = (class_count < 256) ? class_count : 256;
        if (class_pos >= limit) return;
        d.label = class_pos[7:0];
        class_pos++;
        if (!(logit > threshold)) return;
        d.confidence = sigmoid(logit);
        foreach (edges[k]) d.edge_q4[k] = edges[k][19:0];
        pending = {pending, d};
      end
    endfunction

    function void check_result(logic [103:0] word);
      detection_t d;
      string names [4] = '{"x_min", "y_min", "x_max", "y_max"};
      if (pending.size() == 0) begin
        $error("unexpected result word %h", word);
        errors++;
        return;
      end
      d = pending.pop_front();
      if (word[7:0] !== d.label) begin
        $error("label: expected %0d, actual %0d", d.label, word[7:0]);
        errors++;
      end
      if (word[23:8] !== d.confidence) begin
        $error("confidence: expected %0d, actual %0d", d.confidence, word[23:8]);
        errors++;
      end
      for (int k = 0; k < 4; k++) begin
        if (word[24 + 20 * k +: 20] !== d.edge_q4[k]) begin
          $error("%s: expected %0d, actual %0d", names[k], d.edge_q4[k],
                 $signed(word[24 + 20 * k +: 20]));
          errors++;
        end
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = REG_THRESHOLD;
  logic [15:0] cfg_data = '0;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [31:0] s_tdata = '0;
  logic s_tuser = 1'b0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [103:0] m_tdata;

  detection_board board = new();
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_request = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int cycles = 0;

  dfl_box_decode_conf_filter uut (.*);

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_request != hold_seen) begin
      hold_seen <= hold_request;
      hold_left <= HOLD_CYCLES;
      m_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(negedge clk) begin
    if (!rst && m_tvalid && m_tready) board.check_result(m_tdata);
  end

  task automatic send_word(logic cmd, logic [15:0] logit, logic [7:0] cx, logic [7:0] cy);
    logic taken;
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= cmd;
    s_tdata <= {cy, cx, logit};
    do begin
      @(negedge clk);
      taken = s_tready;
      @(posedge clk);
    end while (!taken);
    board.note_input(cmd, logit, cx, cy);
  endtask

  task automatic wait_all_results();
    s_tvalid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_regs(logic [15:0] thr, logic [15:0] stride, logic [15:0] ncls);
    logic [1:0] idx [3] = '{REG_THRESHOLD, REG_STRIDE, REG_CLASS_COUNT};
    logic [15:0] val [3];
    val = '{thr, stride, ncls};
    for (int i = 0; i < 3; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= idx[i];
      cfg_data <= val[i];
      board.write_reg(idx[i], val[i]);
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  function automatic logic [15:0] class_logit();
    case ($urandom_range(3))
      0: return 16'($urandom);
      1: return board.threshold + 16'($urandom_range(4)) - 16'd2;
      2: return $urandom_range(1) ? 16'h7FFF : 16'h8000;
      default: return 16'($signed($urandom_range(3072)) - 1536);
    endcase
  endfunction

  task automatic send_cell(logic [7:0] cx, logic [7:0] cy, int nclasses);
    logic [15:0] base;
    int peak, mode;
    for (int side = 0; side < 4; side++) begin
      mode = $urandom_range(3);
      base = 16'($urandom);
      peak = $urandom_range(15);
      for (int k = 0; k < 16; k++) begin
        case (mode)
          0: send_word(1'b0, 16'($urandom), cx, cy);
          1: send_word(1'b0, base + 16'($urandom_range(1023)), cx, cy);
          2: send_word(1'b0, (k == peak) ? 16'h7FFF : 16'h8000, cx, cy);
          default: send_word(1'b0, 16'($signed($urandom_range(2048)) - 1024), cx, cy);
        endcase
      end
    end
    for (int c = 0; c < nclasses; c++) send_word(1'b1, class_logit(), cx, cy);
  endtask

  initial begin
    logic [15:0] thr_list [8];
    logic [15:0] ncls_list [8];
    int nclasses, ncls_cap;
    thr_list = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFF00, 16'h0100,
                 16'h8000, 16'hFE00, 16'h0080};
    ncls_list = '{16'd1, 16'd256, 16'd0, 16'd511, 16'd7, 16'd12, 16'd80, 16'd5};
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Class words before any side has closed report zero box edges.
    send_word(1'b1, 16'h7FFF, 8'd0, 8'd0);
    send_word(1'b1, 16'h8000, 8'd0, 8'd0);
    send_word(1'b1, 16'h0000, 8'd0, 8'd0);
    send_word(1'b1, 16'h0001, 8'd0, 8'd0);
    for (int side = 0; side < 4; side++) begin
      for (int k = 0; k < 16; k++) send_word(1'b0, (k == 15) ? 16'h7FFF : 16'h8000,
                                              8'd255, 8'd255);
    end
    send_word(1'b1, 16'h0100, 8'd255, 8'd255);
    for (int side = 0; side < 4; side++) begin
      for (int k = 0; k < 16; k++) send_word(1'b0, 16'h8000, 8'd0, 8'd0);
    end
    send_word(1'b1, 16'h7FFF, 8'd0, 8'd0);
    wait_all_results();

    for (int p = 0; p < 8; p++) begin
      set_regs(thr_list[p], 16'(p), ncls_list[p]);
      send_idle_pct = (p % 4 == 1 || p % 4 == 3) ? ((p % 4 == 3) ? 34 : 84) : 0;
      recv_stall_pct = (p % 4 == 2 || p % 4 == 3) ? ((p % 4 == 3) ? 34 : 84) : 0;
      ncls_cap = (board.class_count < 20) ? board.class_count + 3 : 20;
      for (int c = 0; c < 2; c++) begin
        nclasses = (p == 1 && c == 0) ? 260 : $urandom_range(ncls_cap);
        send_cell(8'($urandom), 8'($urandom), nclasses);
        if ($urandom_range(3) == 0) begin
          for (int n = $urandom_range(1, 5); n > 0; n--)
            send_word(1'($urandom_range(1)), 16'($urandom), 8'($urandom), 8'($urandom));
        end
      end
      wait_all_results();
    end

    // Long receiver hold-off while the sender keeps offering passing class words.
    set_regs(16'h8000, 16'd4, 16'd256);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_request <= hold_request + 1;
    send_cell(8'd17, 8'd200, 40);
    wait_all_results();

    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ----- dfl_box_decode_conf_filter.f -----
hdl/dfl_pkg.sv
hdl/dfl_exp.sv
hdl/dfl_div.sv
hdl/dfl_dp.sv
hdl/dfl_ctrl.sv
hdl/dfl_box_decode_conf_filter.sv
test/tb_top.sv
